>>> hdl/heading_turn_rate_ramp_core_assert.svh
// assertion macros for the turn rate ramp core
`ifndef HEADING_TURN_RATE_RAMP_CORE_ASSERT_SVH
`define HEADING_TURN_RATE_RAMP_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HTRR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htrr same-cycle check failed");

// next-cycle implication, checked out of reset
`define HTRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htrr next-cycle check failed");

`endif

>>> hdl/htrr_pkg.sv
// types, constants and widths shared by the turn rate ramp core
package htrr_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int RATE_BITS  = 16;

  localparam int STEP_W = 15;
  localparam int TOL_W  = 15;
  localparam int WAIT_W = 4;
  localparam int TICK_W = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // working width of the rate update: room for rate plus step plus sign
  localparam int SUM_W = ((RATE_BITS > STEP_W) ? RATE_BITS : STEP_W) + 2;
  // compare width of heading error against the tolerance
  localparam int TCMP_W = ((ANGLE_BITS + 1) > TOL_W) ? (ANGLE_BITS + 1) : TOL_W;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE_STEP    = 2'd0,
    CFG_REACH_TOL    = 2'd1,
    CFG_WAIT_LINE    = 2'd2,
    CFG_WAIT_NO_LINE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [STEP_W-1:0] rate_step;
    logic [TOL_W-1:0]  reach_tolerance;
    logic [WAIT_W-1:0] wait_with_line;
    logic [WAIT_W-1:0] wait_without_line;
  } cfg_t;

  typedef struct packed {
    func_t                        func;
    logic [ANGLE_BITS-1:0]        yaw;
    logic [ANGLE_BITS-1:0]        dest_yaw;
    logic signed [RATE_BITS-1:0]  dest_rate;
    logic                         line_seen;
  } item_t;

  typedef struct packed {
    logic                        running;
    logic signed [RATE_BITS-1:0] rate;
  } res_t;

  typedef struct packed {
    logic                        active;
    logic [TICK_W-1:0]           tick_count;
    logic [WAIT_W-1:0]           wait_len;
    logic [ANGLE_BITS-1:0]       start_heading;
    logic [ANGLE_BITS-1:0]       target_heading;
    logic signed [RATE_BITS-1:0] target_rate;
    logic signed [RATE_BITS-1:0] current_rate;
  } state_t;

endpackage

>>> hdl/htrr_if.sv
// handshake channels of the turn rate ramp core: input, result and config
interface htrr_in_if;
  import htrr_pkg::*;
  logic                        valid;
  logic                        ready;
  func_t                       func;
  logic [ANGLE_BITS-1:0]       yaw;
  logic [ANGLE_BITS-1:0]       dest_yaw;
  logic signed [RATE_BITS-1:0] dest_rate;
  logic                        line_seen;
  modport source (output valid, func, yaw, dest_yaw, dest_rate, line_seen, input ready);
  modport sink   (input valid, func, yaw, dest_yaw, dest_rate, line_seen, output ready);
endinterface

interface htrr_out_if;
  import htrr_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        running;
  logic signed [RATE_BITS-1:0] rate;
  modport source (output valid, running, rate, input ready);
  modport sink   (input valid, running, rate, output ready);
endinterface

interface htrr_cfg_if;
  import htrr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/htrr_step.sv
// next-state and result logic for one word of the turn rate ramp
module htrr_step (
  input  htrr_pkg::cfg_t   cfg,
  input  htrr_pkg::state_t st,
  input  htrr_pkg::item_t  item,
  output htrr_pkg::state_t st_nxt,
  output htrr_pkg::res_t   res
);
  import htrr_pkg::*;

  localparam logic signed [SUM_W-1:0] RMAX = SUM_W'({1'b0, {(RATE_BITS-1){1'b1}}});

  logic [TICK_W-1:0]            tick_inc;
  logic signed [ANGLE_BITS-1:0] d0;
  logic signed [ANGLE_BITS-1:0] dn;
  logic signed [ANGLE_BITS:0]   dn_ext;
  logic [ANGLE_BITS:0]          adn;
  logic                         crossed;
  logic                         reached;
  logic signed [SUM_W-1:0]      tr_ext;
  logic signed [SUM_W-1:0]      mag;
  logic signed [SUM_W-1:0]      hi;
  logic signed [SUM_W-1:0]      step_ext;
  logic signed [SUM_W-1:0]      r_sum;
  logic signed [SUM_W-1:0]      r_lo;
  logic signed [SUM_W-1:0]      r_clamp;

  assign tick_inc = (st.tick_count != '1) ? st.tick_count + TICK_W'(1) : st.tick_count;

  // wrapped heading differences are plain subtractions
  assign d0      = signed'(st.target_heading - st.start_heading);
  assign dn      = signed'(st.target_heading - item.yaw);
  assign dn_ext  = (ANGLE_BITS+1)'(dn);
  assign adn     = unsigned'(dn_ext[ANGLE_BITS] ? -dn_ext : dn_ext);
  assign crossed = (!d0[ANGLE_BITS-1] && (d0 != '0) && dn[ANGLE_BITS-1]) ||
                   (d0[ANGLE_BITS-1] && !dn[ANGLE_BITS-1] && (dn != '0));
  assign reached = TCMP_W'(adn) < TCMP_W'(cfg.reach_tolerance);

  // rate step toward the target side, clamped to the target magnitude
  assign tr_ext   = SUM_W'(st.target_rate);
  assign mag      = tr_ext[SUM_W-1] ? -tr_ext : tr_ext;
  assign hi       = (mag > RMAX) ? RMAX : mag;
  assign step_ext = signed'(SUM_W'(cfg.rate_step));
  assign r_sum    = dn[ANGLE_BITS-1] ? SUM_W'(st.current_rate) - step_ext
                                     : SUM_W'(st.current_rate) + step_ext;
  assign r_lo     = (r_sum < -mag) ? -mag : r_sum;
  assign r_clamp  = (r_lo > hi) ? hi : r_lo;

  always_comb begin
    st_nxt = st;
    case (item.func)
      FUNC_START: begin
        st_nxt.start_heading  = item.yaw;
        st_nxt.target_heading = item.dest_yaw;
        st_nxt.target_rate    = item.dest_rate;
        st_nxt.current_rate   = '0;
        st_nxt.wait_len       = item.line_seen ? cfg.wait_with_line : cfg.wait_without_line;
        st_nxt.tick_count     = '0;
        st_nxt.active         = 1'b1;
      end
      FUNC_STOP: begin
        st_nxt.active = 1'b0;
      end
      FUNC_TICK: begin
        if (st.active) begin
          st_nxt.tick_count = tick_inc;
          if (tick_inc <= TICK_W'(st.wait_len)) begin
            st_nxt.current_rate = '0;
          end else if (st.target_rate == '0) begin
            st_nxt.active = 1'b0;
          end else if (crossed || reached) begin
            st_nxt.active = 1'b0;
          end else begin
            st_nxt.current_rate = RATE_BITS'(r_clamp);
          end
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

  assign res.running = st_nxt.active;
  assign res.rate    = st_nxt.active ? st_nxt.current_rate : '0;

endmodule

>>> hdl/heading_turn_rate_ramp_core.sv
// turn rate ramp core top level: input register, step logic, result register
// an accepted word is held in the input register, then its result loads the result register
// throughput: one word per cycle while the receiver keeps up, set by the single step pass between registers
// the run state is updated at the same edge the result register loads
// reset (rst_n low, synchronous): pipeline empty, run idle, all state zero,
// config back to rate_step 161, tolerance 18, waits 5 and 1
module heading_turn_rate_ramp_core (
  input  logic       clk,
  input  logic       rst_n,
  htrr_in_if.sink    in_ch,
  htrr_out_if.source out_ch,
  htrr_cfg_if.sink   cfg_ch
);
  import htrr_pkg::*;

  `include "heading_turn_rate_ramp_core_assert.svh"

  // input register stage
  logic   s1_vld_r;
  item_t  s1_item_r;

  // run state and config
  state_t state_r;
  state_t state_nxt;
  cfg_t   cfg_r;

  // result register stage
  logic   out_vld_r;
  res_t   out_res_r;
  res_t   res_nxt;

  logic   adv;
  logic   in_take;
  item_t  in_item;

  // stage 1 moves on when the result register is empty or being drained
  assign adv      = !out_vld_r || out_ch.ready;
  assign in_ch.ready = !s1_vld_r || adv;
  assign in_take  = in_ch.valid && in_ch.ready;

  assign in_item.func      = in_ch.func;
  assign in_item.yaw       = in_ch.yaw;
  assign in_item.dest_yaw  = in_ch.dest_yaw;
  assign in_item.dest_rate = in_ch.dest_rate;
  assign in_item.line_seen = in_ch.line_seen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
  end

  // one pass of the ramp logic on the registered word
  htrr_step u_step (
    .cfg    (cfg_r),
    .st     (state_r),
    .item   (s1_item_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // state commits only when the word actually leaves stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_vld_r && adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.running = out_res_r.running;
  assign out_ch.rate    = out_res_r.rate;

  // config writes land whenever offered; values are cut to register width
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rate_step         <= STEP_W'(161);
      cfg_r.reach_tolerance   <= TOL_W'(18);
      cfg_r.wait_with_line    <= WAIT_W'(5);
      cfg_r.wait_without_line <= WAIT_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_RATE_STEP:    cfg_r.rate_step         <= STEP_W'(cfg_ch.data);
        CFG_REACH_TOL:    cfg_r.reach_tolerance   <= TOL_W'(cfg_ch.data);
        CFG_WAIT_LINE:    cfg_r.wait_with_line    <= WAIT_W'(cfg_ch.data);
        CFG_WAIT_NO_LINE: cfg_r.wait_without_line <= WAIT_W'(cfg_ch.data);
        default: begin
        end
      endcase
    end
  end

  // an idle result never carries a rate
  `HTRR_ASSERT_NOW(a_idle_rate_zero, out_vld_r && !out_res_r.running, out_res_r.rate == '0)
  // a start word arms the run with zero rate
  `HTRR_ASSERT_NEXT(a_start_arms, s1_vld_r && adv && (s1_item_r.func == FUNC_START),
                    state_r.active && (state_r.current_rate == '0) && (state_r.tick_count == '0))
  // every word leaving stage 1 lands in the result register
  `HTRR_ASSERT_NEXT(a_stage_advance, s1_vld_r && adv, out_vld_r)

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for the heading turn rate ramp core
module testbench;
  import htrr_pkg::*;

  // kind code 3 has no member in func_t: the block must leave its run alone
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int RATE_MAX = 2 ** (RATE_BITS - 1) - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT = 14;

  logic clk;
  logic rst_n;

  htrr_in_if  in_if();
  htrr_out_if out_if();
  htrr_cfg_if cfg_if();

  heading_turn_rate_ramp_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // predictor copy of the registers and of the run state
  cfg_t   knobs;
  state_t ramp;

  // one predicted result word per accepted input word, oldest first
  res_t pending_rates[$];

  int mismatches = 0;
  int words_sent = 0;
  int cycle_cnt = 0;
  bit no_gaps = 1'b0;   // both sides stream without idling while set
  int rx_hold = 0;      // receiver stall length, counted down in the receiver process

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // watchdog
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // wrapped signed heading difference dst - src
  function automatic int hd_delta(logic [ANGLE_BITS-1:0] src, logic [ANGLE_BITS-1:0] dst);
    logic signed [ANGLE_BITS-1:0] d;
    d = dst - src;
    return int'(d);
  endfunction

  // advance the ramp state by one accepted word and return the result word
  function automatic res_t advance_ramp(item_t w);
    int d0, dn, adn, mag, hi, r;
    res_t res;
    case (w.func)
      FUNC_START: begin
        ramp.start_heading  = w.yaw;
        ramp.target_heading = w.dest_yaw;
        ramp.target_rate    = w.dest_rate;
        ramp.current_rate   = '0;
        ramp.wait_len       = w.line_seen ? knobs.wait_with_line : knobs.wait_without_line;
        ramp.tick_count     = '0;
        ramp.active         = 1'b1;
      end
      FUNC_STOP: ramp.active = 1'b0;
      FUNC_TICK: begin
        if (ramp.active) begin
          // tick counter saturates at all ones
          if (ramp.tick_count != '1) ramp.tick_count = ramp.tick_count + 1'b1;
          if (ramp.tick_count <= {1'b0, ramp.wait_len}) begin
            ramp.current_rate = '0;
          end else if (ramp.target_rate == 0) begin
            ramp.active = 1'b0;
          end else begin
            d0  = hd_delta(ramp.start_heading, ramp.target_heading);
            dn  = hd_delta(w.yaw, ramp.target_heading);
            adn = (dn < 0) ? -dn : dn;
            // crossed the target since start, or close enough
            if ((d0 > 0 && dn < 0) || (d0 < 0 && dn > 0) ||
                adn < int'(knobs.reach_tolerance)) begin
              ramp.active = 1'b0;
            end else begin
              mag = (ramp.target_rate < 0) ? -int'(ramp.target_rate) : int'(ramp.target_rate);
              hi  = (mag > RATE_MAX) ? RATE_MAX : mag;
              r   = int'(ramp.current_rate);
              if (dn >= 0) r = r + int'(knobs.rate_step);
              else r = r - int'(knobs.rate_step);
              if (r < -mag) r = -mag;
              if (r > hi) r = hi;
              ramp.current_rate = RATE_BITS'(r);
            end
          end
        end
      end
      default: ;  // spare kind: nothing changes
    endcase
    res.running = ramp.active;
    res.rate    = ramp.active ? ramp.current_rate : '0;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard: everything sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    item_t word_in;
    res_t  want;
    if (!rst_n) begin
      ramp  = '0;
      knobs = '{rate_step: 15'd161, reach_tolerance: 15'd18,
                wait_with_line: 4'd5, wait_without_line: 4'd1};
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_idx_t'(cfg_if.index))
          CFG_RATE_STEP:    knobs.rate_step         = cfg_if.data[STEP_W-1:0];
          CFG_REACH_TOL:    knobs.reach_tolerance   = cfg_if.data[TOL_W-1:0];
          CFG_WAIT_LINE:    knobs.wait_with_line    = cfg_if.data[WAIT_W-1:0];
          CFG_WAIT_NO_LINE: knobs.wait_without_line = cfg_if.data[WAIT_W-1:0];
          default: ;
        endcase
      end
      // input side first so a result that came out with its own word would still find that word
      if (in_if.valid && in_if.ready) begin
        word_in.func      = in_if.func;
        word_in.yaw       = in_if.yaw;
        word_in.dest_yaw  = in_if.dest_yaw;
        word_in.dest_rate = in_if.dest_rate;
        word_in.line_seen = in_if.line_seen;
        pending_rates.push_back(advance_ramp(word_in));
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_rates.size() == 0) begin
          $error("result word with nothing pending: running %0d, rate %0d",
                 out_if.running, out_if.rate);
          mismatches++;
        end else begin
          want = pending_rates.pop_front();
          if (out_if.running !== want.running) begin
            $error("running: expected %0d, actual %0d", want.running, out_if.running);
            mismatches++;
          end
          if (out_if.rate !== want.rate) begin
            $error("rate: expected %0d, actual %0d", want.rate, out_if.rate);
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stalls, plus a long hold on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_if.ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_if.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one input word, maybe after a gap, and wait for the handshake
  task automatic send_word(item_t w);
    @(negedge clk);
    if (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= w.func;
    in_if.yaw       <= w.yaw;
    in_if.dest_yaw  <= w.dest_yaw;
    in_if.dest_rate <= w.dest_rate;
    in_if.line_seen <= w.line_seen;
    do @(posedge clk); while (!in_if.ready);
    words_sent++;
  endtask

  task automatic send_fields(func_t f, logic [ANGLE_BITS-1:0] yaw,
                             logic [ANGLE_BITS-1:0] dest,
                             logic signed [RATE_BITS-1:0] rate, bit line);
    item_t w;
    w.func      = f;
    w.yaw       = yaw;
    w.dest_yaw  = dest;
    w.dest_rate = rate;
    w.line_seen = line;
    send_word(w);
  endtask

  // stop offering and wait until every predicted word has come back
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_knob(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic load_knobs(logic [CFG_DATA_W-1:0] step, logic [CFG_DATA_W-1:0] tol,
                            logic [CFG_DATA_W-1:0] wait_line,
                            logic [CFG_DATA_W-1:0] wait_no_line);
    write_knob(CFG_RATE_STEP, step);
    write_knob(CFG_REACH_TOL, tol);
    write_knob(CFG_WAIT_LINE, wait_line);
    write_knob(CFG_WAIT_NO_LINE, wait_no_line);
  endtask

  // target rate: mostly moderate, with zero and both extremes mixed in
  function automatic logic signed [RATE_BITS-1:0] pick_target_rate();
    int mag;
    mag = $urandom_range(1, 12000);
    case ($urandom_range(9))
      0:       return '0;
      1:       return {1'b1, {(RATE_BITS-1){1'b0}}};
      2:       return {1'b0, {(RATE_BITS-1){1'b1}}};
      3, 4:    return RATE_BITS'($urandom);
      default: return ($urandom_range(1) != 0) ? RATE_BITS'(mag) : RATE_BITS'(-mag);
    endcase
  endfunction

  // any kind, any fields
  task automatic noise_word();
    item_t w;
    w.func      = func_t'($urandom_range(3));
    w.yaw       = ANGLE_BITS'($urandom);
    w.dest_yaw  = ANGLE_BITS'($urandom);
    w.dest_rate = RATE_BITS'($urandom);
    w.line_seen = 1'($urandom);
    send_word(w);
  endtask

  // one well-formed run: a start, then ticks with the heading drifting toward
  // the target, broken now and then by stops, restarts and spare words
  task automatic ramp_run(int max_ticks);
    item_t w;
    logic [ANGLE_BITS-1:0] cur_hd, goal_hd;
    int off, d0, dn, move, div, jit, n_ticks, since, hold_ticks, roll;
    bit slow, done;
    w.func = FUNC_START;
    w.yaw  = ANGLE_BITS'($urandom);
    off = $urandom_range(1, 16000);
    if ($urandom_range(1) != 0) off = -off;
    case ($urandom_range(9))
      0:       goal_hd = w.yaw;                    // no heading change asked
      1, 2:    goal_hd = ANGLE_BITS'($urandom);
      default: goal_hd = w.yaw + ANGLE_BITS'(off);
    endcase
    w.dest_yaw  = goal_hd;
    w.dest_rate = pick_target_rate();
    w.line_seen = 1'($urandom);
    send_word(w);
    hold_ticks = w.line_seen ? knobs.wait_with_line : knobs.wait_without_line;
    cur_hd  = w.yaw;
    d0      = hd_delta(cur_hd, goal_hd);
    slow    = ($urandom_range(3) == 0);
    done    = 1'b0;
    since   = 0;
    n_ticks = $urandom_range(1, max_ticks);
    for (int k = 0; k < n_ticks && !done; k++) begin
      roll = $urandom_range(99);
      w.dest_yaw  = ANGLE_BITS'($urandom);
      w.dest_rate = RATE_BITS'($urandom);
      w.line_seen = 1'($urandom);
      if (roll < 3) begin
        w.func = FUNC_STOP;
        w.yaw  = cur_hd;
        send_word(w);
        done = 1'b1;
      end else if (roll < 5) begin
        // restart from where the heading is now
        w.func      = FUNC_START;
        w.yaw       = cur_hd;
        w.dest_yaw  = goal_hd;
        w.dest_rate = pick_target_rate();
        send_word(w);
        hold_ticks = w.line_seen ? knobs.wait_with_line : knobs.wait_without_line;
        d0    = hd_delta(cur_hd, goal_hd);
        since = 0;
      end else if (roll < 8) begin
        w.func = func_t'(FUNC_SPARE);
        w.yaw  = ANGLE_BITS'($urandom);
        send_word(w);
      end else begin
        dn = hd_delta(cur_hd, goal_hd);
        if (roll < 11) begin
          cur_hd = ANGLE_BITS'($urandom);
        end else if (slow) begin
          move = $urandom_range(0, 40);
          cur_hd = cur_hd + ANGLE_BITS'((dn < 0) ? -move : move);
        end else begin
          div = $urandom_range(2, 10);
          jit = $urandom_range(0, 16);
          cur_hd = cur_hd + ANGLE_BITS'(dn / div + jit - 8);
        end
        w.func = FUNC_TICK;
        w.yaw  = cur_hd;
        send_word(w);
        since++;
        // quit once the block has ended the run on its own
        dn = hd_delta(cur_hd, goal_hd);
        if (since > hold_ticks &&
            ((d0 > 0 && dn < 0) || (d0 < 0 && dn > 0) ||
             ((dn < 0) ? -dn : dn) < int'(knobs.reach_tolerance)))
          done = 1'b1;
      end
    end
  endtask

  task automatic random_runs(int n);
    int goal_cnt;
    goal_cnt = words_sent + n;
    while (words_sent < goal_cnt) begin
      if ($urandom_range(9) == 0) noise_word();
      else ramp_run(45);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // ticks, stops and spare words with no run going
  task automatic test_idle_kinds();
    send_fields(FUNC_TICK, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 1'b1);
    send_fields(func_t'(FUNC_SPARE), 16'h0000, 16'h0000, 16'sh0000, 1'b0);
    send_fields(FUNC_STOP, 16'h1234, 16'h4321, -16'sd5, 1'b0);
  endtask

  // long wait, then ramp up; most negative target rate saturates the upper bound
  task automatic test_default_ramp();
    send_fields(FUNC_START, 16'h0000, 16'h4000, 16'sh8000, 1'b1);
    for (int k = 0; k < 8; k++) begin
      send_fields(FUNC_TICK, ANGLE_BITS'(16 * k), 16'h0000, 16'sh0000, 1'b0);
      if (k == 6) send_fields(func_t'(FUNC_SPARE), 16'h2000, 16'h0000, 16'sh0000, 1'b0);
    end
  endtask

  // start on top of a live run, step downward, then stop
  task automatic test_restart_and_stop();
    send_fields(FUNC_START, 16'hC000, 16'h8000, 16'sh7FFF, 1'b0);
    send_fields(FUNC_TICK, 16'hBFF0, 16'h0000, 16'sh0000, 1'b0);
    send_fields(FUNC_TICK, 16'hBF00, 16'h0000, 16'sh0000, 1'b0);
    send_fields(FUNC_STOP, 16'hBE00, 16'h0000, 16'sh0000, 1'b0);
  endtask

  // zero target rate ends the run on the first tick after the wait
  task automatic test_zero_target();
    send_fields(FUNC_START, 16'h0100, 16'h0900, 16'sh0000, 1'b0);
    send_fields(FUNC_TICK, 16'h0100, 16'h0000, 16'sh0000, 1'b0);
    send_fields(FUNC_TICK, 16'h0100, 16'h0000, 16'sh0000, 1'b0);
  endtask

  // overshoot ends the run; error equal to the tolerance keeps it going
  task automatic test_crossing_and_tolerance();
    send_fields(FUNC_START, 16'h1000, 16'h2000, 16'sd1000, 1'b0);
    send_fields(FUNC_TICK, 16'h1000, 16'h0000, 16'sh0000, 1'b0);
    send_fields(FUNC_TICK, 16'h2001, 16'h0000, 16'sh0000, 1'b0);
    send_fields(FUNC_START, 16'h1000, 16'h2000, -16'sd1000, 1'b0);
    send_fields(FUNC_TICK, 16'h1000, 16'h0000, 16'sh0000, 1'b0);
    send_fields(FUNC_TICK, 16'h1FEE, 16'h0000, 16'sh0000, 1'b0);
    send_fields(FUNC_TICK, 16'h1FEF, 16'h0000, 16'sh0000, 1'b0);
  endtask

  task automatic test_default_random();
    random_runs(350);
  endtask

  // register extremes; wide data to the wait registers checks the masking
  task automatic test_extreme_settings();
    settle();
    load_knobs(15'h7FFF, 15'h0000, 15'h0000, 15'h0000);
    random_runs(200);
    settle();
    load_knobs(15'h0000, 15'h7FFF, 15'h7FFF, 15'h5A5F);
    random_runs(120);
  endtask

  // receiver holds off long enough for the block to back up into the sender
  task automatic test_backpressure();
    settle();
    load_knobs(15'($urandom_range(1, 3000)), 15'($urandom_range(0, 400)),
               15'($urandom_range(0, 15)), 15'($urandom_range(0, 15)));
    rx_hold = 300;
    random_runs(80);
    settle();
  endtask

  // back-to-back words, receiver always ready
  task automatic test_steady_stream();
    no_gaps = 1'b1;
    random_runs(280);
    no_gaps = 1'b0;
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      settle();
      load_knobs(15'($urandom_range(1, 3000)), 15'($urandom_range(0, 16384)),
                 15'($urandom_range(0, 15)), 15'($urandom_range(0, 15)));
      random_runs(150);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.func       = FUNC_TICK;
    in_if.yaw        = '0;
    in_if.dest_yaw   = '0;
    in_if.dest_rate  = '0;
    in_if.line_seen  = 1'b0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_kinds();
    test_default_ramp();
    test_restart_and_stop();
    test_zero_target();
    test_crossing_and_tolerance();
    test_default_random();
    test_extreme_settings();
    test_backpressure();
    test_steady_stream();
    test_random_settings();

    // drain, then give the pipeline time to show any stray word
    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_rates.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
